[hdl/yuvbgr_pkg.sv]
// ----------------------------------------------------------------------------
// YUYV to BGR package
// Shared types and constants for the packed 4:2:2 to BGR pixel converter.
// ----------------------------------------------------------------------------
package yuvbgr_pkg;

  // Byte position inside one Y0 U Y1 V group.
  typedef enum logic [1:0] {
    PH_Y0 = 2'd0,
    PH_U  = 2'd1,
    PH_Y1 = 2'd2,
    PH_V  = 2'd3
  } phase_t;

  // One complete group, as handed from the byte front end to the pixel back end.
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       frame_end;
  } grp_t;

  // Status of the group queue.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Number of groups the queue can hold.
  localparam int GRP_QUEUE_DEPTH = 4;

  // Coefficients in thousandths.
  localparam int COEF_BU_MILLI = 1772;
  localparam int COEF_GU_MILLI = 344;
  localparam int COEF_GV_MILLI = 714;
  localparam int COEF_RV_MILLI = 1402;

endpackage

[hdl/yuvbgr_front.sv]
// ----------------------------------------------------------------------------
// YUYV byte front end
// Tracks the byte phase, holds Y0, U and Y1, and pushes a complete group
// into the queue on the V byte.
// ----------------------------------------------------------------------------
module yuvbgr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_last,
  input  yuvbgr_pkg::qstat_t q_stat,
  output logic               push,
  output yuvbgr_pkg::grp_t   push_grp
);
  import yuvbgr_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] luma_first_r;
  logic [7:0] chroma_blue_r;
  logic [7:0] luma_second_r;
  logic       accept;

  // Only the V byte needs room in the queue; other bytes are always taken.
  assign in_stall = q_stat.full && (phase_r == PH_V);
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (phase_r == PH_V);

  assign push_grp.luma_first  = luma_first_r;
  assign push_grp.luma_second = luma_second_r;
  assign push_grp.chroma_blue = chroma_blue_r;
  assign push_grp.chroma_red  = in_data_byte;
  assign push_grp.frame_end   = in_frame_last;

  // The last byte of a frame returns the phase to the start of a group.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_frame_last) begin
        phase_nxt = PH_Y0;
      end else begin
        phase_nxt = phase_t'(phase_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_Y0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Hold the first three bytes of the group.
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (phase_r)
        PH_Y0:   luma_first_r  <= in_data_byte;
        PH_U:    chroma_blue_r <= in_data_byte;
        PH_Y1:   luma_second_r <= in_data_byte;
        default: ;
      endcase
    end
  end

endmodule

[hdl/yuvbgr_fifo.sv]
// ----------------------------------------------------------------------------
// YUYV group queue
// Small register queue that decouples the byte front end from the pixel
// back end.
// ----------------------------------------------------------------------------
module yuvbgr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  yuvbgr_pkg::grp_t   push_grp,
  input  logic               pop,
  output yuvbgr_pkg::grp_t   head_grp,
  output yuvbgr_pkg::qstat_t q_stat
);
  import yuvbgr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign head_grp     = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

  // Pointer and fill count update, with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

[hdl/yuvbgr_back.sv]
// ----------------------------------------------------------------------------
// YUYV pixel back end
// Expands each group into two pixels and converts them to clamped BGR in a
// two-stage pipeline: products first, then sums with clamping.
// ----------------------------------------------------------------------------
module yuvbgr_back #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  yuvbgr_pkg::grp_t   head_grp,
  input  yuvbgr_pkg::qstat_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_green,
  output logic [7:0]         out_red,
  output logic               out_pair_last,
  output logic               out_frame_end
);
  import yuvbgr_pkg::*;

  localparam int F      = COEF_FRAC_BITS;
  localparam int COEF_W = F + 2;
  localparam int SUM_W  = F + 11;

  localparam int C_BU_I = ((COEF_BU_MILLI << F) + 500) / 1000;
  localparam int C_GU_I = ((COEF_GU_MILLI << F) + 500) / 1000;
  localparam int C_GV_I = ((COEF_GV_MILLI << F) + 500) / 1000;
  localparam int C_RV_I = ((COEF_RV_MILLI << F) + 500) / 1000;

  localparam logic signed [COEF_W-1:0] C_BU = COEF_W'(C_BU_I);
  localparam logic signed [COEF_W-1:0] C_GU = COEF_W'(C_GU_I);
  localparam logic signed [COEF_W-1:0] C_GV = COEF_W'(C_GV_I);
  localparam logic signed [COEF_W-1:0] C_RV = COEF_W'(C_RV_I);

  // Upper clamp bound: 255 in the fixed-point scale.
  localparam logic signed [SUM_W-1:0] TOP = SUM_W'(255) <<< F;

  logic                    pix_sel_r;
  logic                    issue;
  logic                    s1_ready;
  logic                    out_ready;
  logic signed [7:0]       u_s;
  logic signed [7:0]       v_s;
  logic signed [SUM_W-1:0] u_ext;
  logic signed [SUM_W-1:0] v_ext;

  logic                    s1_valid_r;
  logic [7:0]              s1_luma_r;
  logic signed [SUM_W-1:0] s1_bu_r;
  logic signed [SUM_W-1:0] s1_gu_r;
  logic signed [SUM_W-1:0] s1_gv_r;
  logic signed [SUM_W-1:0] s1_rv_r;
  logic                    s1_pair_last_r;
  logic                    s1_frame_end_r;

  logic signed [SUM_W-1:0] luma_s;
  logic signed [SUM_W-1:0] sum_b;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_r;

  logic                    out_valid_r;
  logic [7:0]              out_blue_r;
  logic [7:0]              out_green_r;
  logic [7:0]              out_red_r;
  logic                    out_pair_last_r;
  logic                    out_frame_end_r;

  // Clamp to 0..255 and drop the fraction bits.
  function automatic logic [7:0] clamp_floor(input logic signed [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum <= 0) begin
      res = 8'd0;
    end else if (sum >= TOP) begin
      res = 8'd255;
    end else begin
      res = sum[F +: 8];
    end
    return res;
  endfunction

  // Flow: each stage loads when it is empty or the stage after it can take data.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign issue     = !q_stat.empty && s1_ready;
  assign pop       = issue && pix_sel_r;

  // Chroma minus 128 is the byte with its top bit inverted, read as signed.
  assign u_s   = signed'({~head_grp.chroma_blue[7], head_grp.chroma_blue[6:0]});
  assign v_s   = signed'({~head_grp.chroma_red[7], head_grp.chroma_red[6:0]});
  assign u_ext = SUM_W'(u_s);
  assign v_ext = SUM_W'(v_s);

  // Pixel select within the current group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_sel_r <= 1'b0;
    end else if (issue) begin
      pix_sel_r <= !pix_sel_r;
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_luma_r      <= pix_sel_r ? head_grp.luma_second : head_grp.luma_first;
      s1_bu_r        <= u_ext * SUM_W'(C_BU);
      s1_gu_r        <= u_ext * SUM_W'(C_GU);
      s1_gv_r        <= v_ext * SUM_W'(C_GV);
      s1_rv_r        <= v_ext * SUM_W'(C_RV);
      s1_pair_last_r <= pix_sel_r;
      s1_frame_end_r <= pix_sel_r && head_grp.frame_end;
    end
  end

  // Sum stage: luma is scaled exactly, then the chroma terms are added.
  assign luma_s = signed'(SUM_W'(s1_luma_r) <<< F);
  assign sum_b  = luma_s + s1_bu_r;
  assign sum_g  = luma_s - s1_gu_r - s1_gv_r;
  assign sum_r  = luma_s + s1_rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_blue_r      <= clamp_floor(sum_b);
      out_green_r     <= clamp_floor(sum_g);
      out_red_r       <= clamp_floor(sum_r);
      out_pair_last_r <= s1_pair_last_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue      = out_blue_r;
  assign out_green     = out_green_r;
  assign out_red       = out_red_r;
  assign out_pair_last = out_pair_last_r;
  assign out_frame_end = out_frame_end_r;

endmodule

[hdl/yuyv_to_bgr_pixel_stream_unit.sv]
// Path: the first pixel of a group passes from its V byte through the group
// queue, the product register and the output register; the second pixel of
// the group follows it through the same registers.
// Throughput: one byte per cycle unless a V byte meets a full queue; the back
// end gives one pixel per cycle while out_stall is low, two per four bytes.
// Reset: synchronous, active low; clears the byte phase, the queue and all
// pipeline valid flags.
// ----------------------------------------------------------------------------
// YUYV to BGR pixel stream unit
// Converts a packed 4:2:2 byte stream into clamped BGR pixels, two per group.
// ----------------------------------------------------------------------------
module yuyv_to_bgr_pixel_stream_unit #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic       out_pair_last,
  output logic       out_frame_end
);
  import yuvbgr_pkg::*;

  logic   push;
  logic   pop;
  grp_t   push_grp;
  grp_t   head_grp;
  qstat_t q_stat;

  // Byte front end.
  yuvbgr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_frame_last (in_frame_last),
    .q_stat        (q_stat),
    .push          (push),
    .push_grp      (push_grp)
  );

  // Group queue between the two halves.
  yuvbgr_fifo #(
    .DEPTH (GRP_QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head_grp (head_grp),
    .q_stat   (q_stat)
  );

  // Pixel conversion back end.
  yuvbgr_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_grp      (head_grp),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_pair_last (out_pair_last),
    .out_frame_end (out_frame_end)
  );

endmodule
